FILE: hdl/eaq_pkg.sv
// ----------------------------------------------------------------------------
// eaq_pkg
// shared types, constants and the arctangent table for the euler angle to
// quaternion pipeline
// ----------------------------------------------------------------------------
package eaq_pkg;

    localparam int SINE_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_STAGES   = (SINE_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES :
                                     ((SINE_ITERATIONS < 1) ? 1 : SINE_ITERATIONS);
    // input register, cordic stages, sign fix stage, five multiply stages
    localparam int PIPE_DEPTH      = CORDIC_STAGES + 7;
    localparam int IDX_W           = $clog2(ATAN_ENTRIES);

    localparam int ANGLE_W = 16;
    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int CW      = 34;
    localparam int SC_W    = 32;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam int                   Q14_ONE     = 16384;

    typedef logic signed [CW-1:0] cordic_word_t;

    typedef struct packed {
        cordic_word_t x;
        cordic_word_t y;
        cordic_word_t z;
    } cordic_lane_t;

    typedef cordic_lane_t [2:0] cordic_vec_t;

    typedef struct packed {
        logic signed [SC_W-1:0] sin_v;
        logic signed [SC_W-1:0] cos_v;
    } sincos_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } pos_t;

    // atan(2^-i) in q.30, truncated (entry 0 rounded)
    function automatic cordic_word_t atan_q30(input logic [IDX_W-1:0] idx);
        cordic_word_t v;
        unique case (idx)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/euler_angles_to_quaternion.sv
// throughput: one pose per cycle while the pipeline runs; the cordic iterations
// and the multiply stages are each a register stage, so a pose enters every cycle
// the pipeline halts only when the two-entry output queue is full and not read
// reset: asynchronous active low, clears valid bits, queue pointers and count only
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion
// pose of three euler angles and a position to a unit quaternion plus the
// unchanged position
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [eaq_pkg::ANGLE_W-1:0] angle_x,
    input  logic signed [eaq_pkg::ANGLE_W-1:0] angle_y,
    input  logic signed [eaq_pkg::ANGLE_W-1:0] angle_z,
    input  logic signed [eaq_pkg::POS_W-1:0]   pos_x,
    input  logic signed [eaq_pkg::POS_W-1:0]   pos_y,
    input  logic signed [eaq_pkg::POS_W-1:0]   pos_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [eaq_pkg::QUAT_W-1:0]  quat_w,
    output logic signed [eaq_pkg::QUAT_W-1:0]  quat_x,
    output logic signed [eaq_pkg::QUAT_W-1:0]  quat_y,
    output logic signed [eaq_pkg::QUAT_W-1:0]  quat_z,
    output logic signed [eaq_pkg::POS_W-1:0]   out_pos_x,
    output logic signed [eaq_pkg::POS_W-1:0]   out_pos_y,
    output logic signed [eaq_pkg::POS_W-1:0]   out_pos_z
);
    import eaq_pkg::*;

    // pipeline map:
    //   stage 0              input register, half-angle range fold
    //   stages 1..N          cordic iterations
    //   stage N+1            sign fix, sine/cosine truncated to 32 bits
    //   stages N+2..N+6      products, rounding, sums (inside eaq_quat_mult)
    //   then                 saturation into the output queue

    logic                  pipe_en;
    logic [PIPE_DEPTH-1:0] valid_pipe_reg;
    pos_t                  pos_pipe_reg [PIPE_DEPTH];
    logic [2:0]            flip_pipe_reg [CORDIC_STAGES+1];
    cordic_vec_t           lane_vec [CORDIC_STAGES+1];
    cordic_vec_t           lane0_reg, lane0_next;
    logic [2:0]            flip0_next;
    sincos_t [2:0]         sc_reg;
    quat_t                 quat_res;
    quat_t                 out_quat;
    pos_t                  out_pos;
    logic                  push;
    logic signed [ANGLE_W-1:0] angle_in [3];

    assign angle_in[0] = angle_x;
    assign angle_in[1] = angle_y;
    assign angle_in[2] = angle_z;

    // the whole pipeline moves together while the output queue has room
    assign in_ready = pipe_en;
    assign push     = pipe_en && valid_pipe_reg[PIPE_DEPTH-1];

    // half angle in q.30 is the raw angle shifted up by 16; fold beyond +-pi/2
    always_comb
    begin
        cordic_word_t z0;
        for (int l = 0; l < 3; l++)
        begin
            z0 = {{(CW-ANGLE_W-16){angle_in[l][ANGLE_W-1]}}, angle_in[l], 16'b0};
            lane0_next[l].x = CORDIC_GAIN;
            lane0_next[l].y = '0;
            flip0_next[l]   = 1'b0;
            if (z0 > HALF_PI_Q30)
            begin
                lane0_next[l].z = z0 - PI_Q30;
                flip0_next[l]   = 1'b1;
            end
            else if (z0 < -HALF_PI_Q30)
            begin
                lane0_next[l].z = z0 + PI_Q30;
                flip0_next[l]   = 1'b1;
            end
            else
            begin
                lane0_next[l].z = z0;
            end
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_pipe_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_pipe_reg <= {valid_pipe_reg[PIPE_DEPTH-2:0], in_valid};
        end
    end

    // payload registers: position line, fold flags, cordic input stage, sign fix
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            pos_pipe_reg[0]  <= '{x: pos_x, y: pos_y, z: pos_z};
            lane0_reg        <= lane0_next;
            flip_pipe_reg[0] <= flip0_next;
            for (int k = 1; k < PIPE_DEPTH; k++)
            begin
                pos_pipe_reg[k] <= pos_pipe_reg[k-1];
            end
            for (int k = 1; k <= CORDIC_STAGES; k++)
            begin
                flip_pipe_reg[k] <= flip_pipe_reg[k-1];
            end
            for (int l = 0; l < 3; l++)
            begin
                if (flip_pipe_reg[CORDIC_STAGES][l])
                begin
                    sc_reg[l].sin_v <= SC_W'(-lane_vec[CORDIC_STAGES][l].y);
                    sc_reg[l].cos_v <= SC_W'(-lane_vec[CORDIC_STAGES][l].x);
                end
                else
                begin
                    sc_reg[l].sin_v <= SC_W'(lane_vec[CORDIC_STAGES][l].y);
                    sc_reg[l].cos_v <= SC_W'(lane_vec[CORDIC_STAGES][l].x);
                end
            end
        end
    end

    assign lane_vec[0] = lane0_reg;

    // one register stage per cordic iteration
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cordic
        eaq_cordic_stage u_stage
        (
            .clk      (clk),
            .en       (pipe_en),
            .idx      (IDX_W'(g)),
            .lane_in  (lane_vec[g]),
            .lane_out (lane_vec[g+1])
        );
    end

    eaq_quat_mult u_mult
    (
        .clk  (clk),
        .en   (pipe_en),
        .sc   (sc_reg),
        .quat (quat_res)
    );

    eaq_out_buf u_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_quat (quat_res),
        .push_pos  (pos_pipe_reg[PIPE_DEPTH-1]),
        .space     (pipe_en),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_quat  (out_quat),
        .out_pos   (out_pos)
    );

    assign quat_w    = out_quat.w;
    assign quat_x    = out_quat.x;
    assign quat_y    = out_quat.y;
    assign quat_z    = out_quat.z;
    assign out_pos_x = out_pos.x;
    assign out_pos_y = out_pos.y;
    assign out_pos_z = out_pos.z;

`ifndef NO_ASSERTIONS
    // an accepted pose occupies the first stage on the next cycle
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_pipe_reg[0])
        else $error("accepted pose missing from first stage");

    // a stalled pipeline keeps its valid bits
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(valid_pipe_reg))
        else $error("valid bits moved during stall");

    // saturation keeps every quaternion part within +-1.0
    a_quat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w <= 16'sd16384 && quat_w >= -16'sd16384 &&
                       quat_x <= 16'sd16384 && quat_x >= -16'sd16384 &&
                       quat_y <= 16'sd16384 && quat_y >= -16'sd16384 &&
                       quat_z <= 16'sd16384 && quat_z >= -16'sd16384))
        else $error("quaternion part beyond saturation limit");

    // the pipeline stalls only while the queue shows a result that is not read
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |-> out_valid && !out_ready)
        else $error("pipeline stalled with free queue space");
`endif

endmodule

FILE: hdl/eaq_cordic_stage.sv
// ----------------------------------------------------------------------------
// eaq_cordic_stage
// one registered rotation-mode cordic iteration for all three angle lanes
// ----------------------------------------------------------------------------
module eaq_cordic_stage
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [eaq_pkg::IDX_W-1:0] idx,
    input  eaq_pkg::cordic_vec_t     lane_in,
    output eaq_pkg::cordic_vec_t     lane_out
);
    import eaq_pkg::*;

    cordic_vec_t  lane_next;
    cordic_vec_t  lane_reg;
    cordic_word_t at;

    always_comb
    begin
        cordic_word_t dx;
        cordic_word_t dy;
        at = atan_q30(idx);
        for (int l = 0; l < 3; l++)
        begin
            dx = $signed(lane_in[l].y) >>> idx;
            dy = $signed(lane_in[l].x) >>> idx;
            if (!lane_in[l].z[CW-1])
            begin
                lane_next[l].x = lane_in[l].x - dx;
                lane_next[l].y = lane_in[l].y + dy;
                lane_next[l].z = lane_in[l].z - at;
            end
            else
            begin
                lane_next[l].x = lane_in[l].x + dx;
                lane_next[l].y = lane_in[l].y - dy;
                lane_next[l].z = lane_in[l].z + at;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

FILE: hdl/eaq_quat_mult.sv
// ----------------------------------------------------------------------------
// eaq_quat_mult
// triple products of half-angle sines and cosines, summed and saturated
// to q1.14 quaternion parts
// ----------------------------------------------------------------------------
module eaq_quat_mult
(
    input  logic                  clk,
    input  logic                  en,
    input  eaq_pkg::sincos_t [2:0] sc,
    output eaq_pkg::quat_t        quat
);
    import eaq_pkg::*;

    // lane 0 = angle_x (q), lane 1 = angle_y (p), lane 2 = angle_z (r)
    logic signed [63:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg;
    sincos_t            q1_reg, q2_reg;
    logic signed [33:0] rcrcp_reg, rsrsp_reg, rsrcp_reg, rcrsp_reg;
    logic signed [65:0] t_reg [8];
    logic signed [35:0] rt_reg [8];
    logic signed [36:0] sum_reg [4];

    logic signed [63:0] rnd_a;
    logic signed [63:0] rnd_b;
    logic signed [63:0] rnd_c;
    logic signed [63:0] rnd_d;
    logic signed [65:0] rnd_t [8];

    always_comb
    begin
        rnd_a = crcp_reg + 64'sd536870912;
        rnd_b = srsp_reg + 64'sd536870912;
        rnd_c = srcp_reg + 64'sd536870912;
        rnd_d = crsp_reg + 64'sd536870912;
        for (int k = 0; k < 8; k++)
        begin
            rnd_t[k] = t_reg[k] + 66'sd536870912;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // pair products
            crcp_reg <= sc[2].cos_v * sc[1].cos_v;
            srsp_reg <= sc[2].sin_v * sc[1].sin_v;
            srcp_reg <= sc[2].sin_v * sc[1].cos_v;
            crsp_reg <= sc[2].cos_v * sc[1].sin_v;
            q1_reg   <= sc[0];
            // round back to q.30
            rcrcp_reg <= $signed(rnd_a[63:30]);
            rsrsp_reg <= $signed(rnd_b[63:30]);
            rsrcp_reg <= $signed(rnd_c[63:30]);
            rcrsp_reg <= $signed(rnd_d[63:30]);
            q2_reg    <= q1_reg;
            // triple products
            t_reg[0] <= rcrcp_reg * q2_reg.cos_v;
            t_reg[1] <= rsrsp_reg * q2_reg.sin_v;
            t_reg[2] <= rsrcp_reg * q2_reg.cos_v;
            t_reg[3] <= rcrsp_reg * q2_reg.sin_v;
            t_reg[4] <= rcrsp_reg * q2_reg.cos_v;
            t_reg[5] <= rsrcp_reg * q2_reg.sin_v;
            t_reg[6] <= rcrcp_reg * q2_reg.sin_v;
            t_reg[7] <= rsrsp_reg * q2_reg.cos_v;
            for (int k = 0; k < 8; k++)
            begin
                rt_reg[k] <= $signed(rnd_t[k][65:30]);
            end
            sum_reg[0] <= 37'(rt_reg[0]) + 37'(rt_reg[1]);
            sum_reg[1] <= 37'(rt_reg[2]) - 37'(rt_reg[3]);
            sum_reg[2] <= 37'(rt_reg[4]) + 37'(rt_reg[5]);
            sum_reg[3] <= 37'(rt_reg[6]) - 37'(rt_reg[7]);
        end
    end

    // round to q1.14 and clamp to +-1.0
    function automatic logic signed [QUAT_W-1:0] to_q14(input logic signed [36:0] v);
        logic signed [36:0] r;
        logic signed [20:0] s;
        r = v + 37'sd32768;
        s = $signed(r[36:16]);
        if (s > 21'sd16384)
        begin
            return 16'sd16384;
        end
        else if (s < -21'sd16384)
        begin
            return -16'sd16384;
        end
        return s[QUAT_W-1:0];
    endfunction

    assign quat.w = to_q14(sum_reg[0]);
    assign quat.x = to_q14(sum_reg[1]);
    assign quat.y = to_q14(sum_reg[2]);
    assign quat.z = to_q14(sum_reg[3]);

endmodule

FILE: hdl/eaq_out_buf.sv
// ----------------------------------------------------------------------------
// eaq_out_buf
// two-entry output queue that decouples the pipeline from the consumer
// ----------------------------------------------------------------------------
module eaq_out_buf
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  eaq_pkg::quat_t push_quat,
    input  eaq_pkg::pos_t  push_pos,
    output logic           space,
    output logic           out_valid,
    input  logic           out_ready,
    output eaq_pkg::quat_t out_quat,
    output eaq_pkg::pos_t  out_pos
);
    import eaq_pkg::*;

    quat_t      quat_mem_reg [2];
    pos_t       pos_mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign space     = (count_reg != 2'd2) || out_ready;
    assign out_quat  = quat_mem_reg[rd_ptr_reg];
    assign out_pos   = pos_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            quat_mem_reg[wr_ptr_reg] <= push_quat;
            pos_mem_reg[wr_ptr_reg]  <= push_pos;
        end
    end

endmodule
